FILE: sv/brdf_pkg.sv
// Shared types and constants for the beacon router with duplicate filter.
// No dependencies; the filter, the top level and the testbench import this package.
`default_nettype none
package brdf_pkg;

	localparam int MSG_BYTES = 8;

	typedef logic [7:0] byte_t;
	typedef byte_t [MSG_BYTES-1:0] msg_t;

	// message kinds on the receive side
	localparam logic [1:0] OP_BEACON  = 2'd0;
	localparam logic [1:0] OP_DATA    = 2'd1;
	localparam logic [1:0] OP_CAPSULE = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	// handler ids on the send side
	localparam logic [2:0] HND_BEACON  = 3'd5;
	localparam logic [2:0] HND_DATA    = 3'd6;
	localparam logic [2:0] HND_CAPSULE = 3'd7;

	// register indexes
	localparam logic [1:0] REG_LOCAL  = 2'd0;
	localparam logic [1:0] REG_BASE   = 2'd1;
	localparam logic [1:0] REG_BCAST  = 2'd2;
	localparam logic [1:0] REG_UPLINK = 2'd3;

	localparam byte_t MAX_HOPS   = 8'd5;
	localparam byte_t HOP_NONE   = 8'hFF;
	localparam byte_t RST_LOCAL  = 8'd1;
	localparam byte_t RST_BCAST  = 8'd255;
	localparam byte_t RST_UPLINK = 8'd126;

endpackage
`default_nettype wire

FILE: sv/brdf_if.sv
// Valid/ready channel interfaces: received message in, outgoing message out.
// Depends on nothing but plain logic types.
`default_nettype none
interface brdf_msg_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] in_byte0;
	logic [7:0] in_byte1;
	logic [7:0] in_byte2;
	logic [7:0] in_byte3;
	logic [7:0] in_byte4;
	logic [7:0] in_byte5;
	logic [7:0] in_byte6;
	logic [7:0] in_byte7;

	modport source (output valid, opcode, in_byte0, in_byte1, in_byte2, in_byte3,
		in_byte4, in_byte5, in_byte6, in_byte7, input ready);
	modport sink (input valid, opcode, in_byte0, in_byte1, in_byte2, in_byte3,
		in_byte4, in_byte5, in_byte6, in_byte7, output ready);
endinterface

interface brdf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_dest;
	logic [2:0] out_handler;
	logic [7:0] out_byte0;
	logic [7:0] out_byte1;
	logic [7:0] out_byte2;
	logic [7:0] out_byte3;
	logic [7:0] out_byte4;
	logic [7:0] out_byte5;
	logic [7:0] out_byte6;
	logic [7:0] out_byte7;

	modport source (output valid, out_dest, out_handler, out_byte0, out_byte1,
		out_byte2, out_byte3, out_byte4, out_byte5, out_byte6, out_byte7, input ready);
	modport sink (input valid, out_dest, out_handler, out_byte0, out_byte1,
		out_byte2, out_byte3, out_byte4, out_byte5, out_byte6, out_byte7, output ready);
endinterface
`default_nettype wire

FILE: sv/brdf_filter.sv
// Ring of recently seen message sums with a parallel lookup.
// Depends on brdf_pkg for byte_t.
`default_nettype none
module brdf_filter
	import brdf_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  byte_t sum,
	input  logic  insert,
	output logic  hit
);

	localparam int PW = $clog2(DEPTH);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	byte_t         ring_q [DEPTH];
	logic [PW-1:0] ptr_q;

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (ring_q[i] == sum) begin
				hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			ptr_q <= '0;
		end else if (insert) begin
			ring_q[ptr_q] <= sum;
			ptr_q         <= (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: sv/beacon_route_with_duplicate_filter_top.sv
// Top level: input register, route/filter decision, output register.
// Depends on brdf_pkg, brdf_if and brdf_filter.
//
//  channel   dir  handshake          payload
//  rx        in   rx.valid/rx.ready  opcode, in_byte0..in_byte7
//  tx        out  tx.valid/tx.ready  out_dest, out_handler, out_byte0..out_byte7
//  wr        in   wr_en              wr_index, wr_data
//
// One beat per cycle sustained while tx is ready; a taken message passes the input register
// and then the output register before it is presented on tx. The work sits between the two: byte sum,
// ring compare against every filter slot, and the byte rewrite.
// A stalled tx holds its beat while one more message waits in the input register.
// arst_n resets the valid flags, configuration and route state, and clears every filter slot to zero.
`default_nettype none
module beacon_route_with_duplicate_filter_top
	import brdf_pkg::*;
#(
	parameter int FILTER_DEPTH = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	brdf_msg_if.sink        rx,
	brdf_out_if.source      tx,
	input  logic            wr_en,
	input  logic [1:0]      wr_index,
	input  logic [7:0]      wr_data
);

	// configuration
	byte_t local_q, bcast_q, uplink_q;
	logic  base_q;

	// route state
	byte_t hop_q, parent_q, epoch_q;

	// input stage
	logic       valid_s1;
	logic [1:0] op_s1;
	msg_t       msg_s1;

	// output stage
	logic  out_valid_q;
	byte_t dest_q;
	logic [2:0] handler_q;
	msg_t  bytes_q;

	logic  adv;
	byte_t sum;
	logic  hit;
	logic  insert;
	logic  emit;
	byte_t dest;
	logic [2:0] handler;
	msg_t  obytes;
	logic  beacon_ok;
	logic [2:0] hop3;
	logic [2:0] slot;

	assign adv      = valid_s1 && (!out_valid_q || tx.ready);
	assign rx.ready = !valid_s1 || adv;

	always_comb begin
		sum = '0;
		for (int i = 0; i < MSG_BYTES; i++) begin
			sum = sum + msg_s1[i];
		end
	end

	brdf_filter #(.DEPTH(FILTER_DEPTH)) u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.sum    (sum),
		.insert (insert),
		.hit    (hit)
	);

	assign hop3      = msg_s1[1][2:0];
	assign slot      = hop3 + 3'd2;
	assign beacon_ok = (msg_s1[1] <= MAX_HOPS) && (msg_s1[1] <= hop_q) && !hit;

	always_comb begin
		emit    = 1'b0;
		insert  = 1'b0;
		dest    = bcast_q;
		handler = HND_CAPSULE;
		obytes  = msg_s1;
		unique case (op_s1)
			OP_BEACON: begin
				emit    = beacon_ok;
				insert  = beacon_ok;
				handler = HND_BEACON;
				for (int i = 0; i < MSG_BYTES; i++) begin
					if (i == 1) begin
						obytes[i] = msg_s1[1] + 8'd1;
					end else if (3'(i) == slot) begin
						obytes[i] = local_q;
					end
				end
			end
			OP_DATA: begin
				emit    = (parent_q != '0);
				dest    = parent_q;
				handler = HND_DATA;
				if (!base_q) begin
					obytes[5] = msg_s1[4];
					obytes[4] = msg_s1[3];
					obytes[3] = msg_s1[2];
					obytes[2] = local_q;
				end
			end
			OP_CAPSULE: begin
				emit   = !hit;
				insert = !hit;
			end
			OP_UNUSED: begin
			end
			default: begin
			end
		endcase
		insert = insert && adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			op_s1     <= rx.opcode;
			msg_s1[0] <= rx.in_byte0;
			msg_s1[1] <= rx.in_byte1;
			msg_s1[2] <= rx.in_byte2;
			msg_s1[3] <= rx.in_byte3;
			msg_s1[4] <= rx.in_byte4;
			msg_s1[5] <= rx.in_byte5;
			msg_s1[6] <= rx.in_byte6;
			msg_s1[7] <= rx.in_byte7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			dest_q    <= dest;
			handler_q <= handler;
			bytes_q   <= obytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q  <= RST_LOCAL;
			base_q   <= 1'b0;
			bcast_q  <= RST_BCAST;
			uplink_q <= RST_UPLINK;
			hop_q    <= HOP_NONE;
			parent_q <= RST_BCAST;
			epoch_q  <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LOCAL:  local_q  <= wr_data;
				REG_BASE: begin
					base_q   <= wr_data[0];
					hop_q    <= wr_data[0] ? '0 : HOP_NONE;
					parent_q <= wr_data[0] ? uplink_q : bcast_q;
				end
				REG_BCAST:  bcast_q  <= wr_data;
				REG_UPLINK: uplink_q <= wr_data;
				default: begin
				end
			endcase
		end else if (adv && op_s1 == OP_BEACON && beacon_ok) begin
			epoch_q  <= msg_s1[0];
			hop_q    <= msg_s1[1];
			// parent is the route entry just below the new hop slot
			parent_q <= msg_s1[hop3 + 3'd1];
		end
	end

	assign tx.valid       = out_valid_q;
	assign tx.out_dest    = dest_q;
	assign tx.out_handler = handler_q;
	assign tx.out_byte0   = bytes_q[0];
	assign tx.out_byte1   = bytes_q[1];
	assign tx.out_byte2   = bytes_q[2];
	assign tx.out_byte3   = bytes_q[3];
	assign tx.out_byte4   = bytes_q[4];
	assign tx.out_byte5   = bytes_q[5];
	assign tx.out_byte6   = bytes_q[6];
	assign tx.out_byte7   = bytes_q[7];

endmodule
`default_nettype wire

FILE: tb/beacon_route_with_duplicate_filter_top_test.sv
// Self-checking test of the beacon router with its duplicate filter.
// Needs brdf_pkg, brdf_if and beacon_route_with_duplicate_filter_top; every
// outgoing beat is predicted from the accepted message stream and compared.
module beacon_route_with_duplicate_filter_top_test
	import brdf_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH  = 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 178;

	typedef struct packed {
		logic [1:0] op;
		msg_t       body;
	} rx_beat_t;

	typedef struct packed {
		byte_t      dest;
		logic [2:0] handler;
		msg_t       body;
	} tx_beat_t;

	typedef enum {RX_STEADY, RX_COIN, RX_LIGHT, RX_PERIODIC} rx_pace_e;

	logic       clk;
	logic       arst_n;
	logic       wr_en;
	logic [1:0] wr_index;
	logic [7:0] wr_data;

	brdf_msg_if rx_if();
	brdf_out_if tx_if();

	beacon_route_with_duplicate_filter_top #(
		.FILTER_DEPTH(RING_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.tx(tx_if),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// node registers and route state as the block should hold them
	byte_t local_addr;
	logic  base_node;
	byte_t bcast_addr;
	byte_t uplink_addr;
	byte_t sum_ring [RING_DEPTH];
	int    ring_slot;
	byte_t hop_cnt;
	byte_t parent_addr;
	byte_t epoch;

	tx_beat_t outbound_msgs [$];
	rx_beat_t sent_log [$];

	int errors;
	int items_sent;
	int beats_checked;
	int msgs_dropped;
	int settings_used;
	int burst_left;
	bit sender_gaps;
	bit hold_req;
	int hold_left;
	int stall_cnt;
	rx_pace_e stall_mode;
	int quiet;

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 30)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	function automatic msg_t msg8(input byte_t b0, b1, b2, b3, b4, b5, b6, b7);
		msg_t m;
		m[0] = b0; m[1] = b1; m[2] = b2; m[3] = b3;
		m[4] = b4; m[5] = b5; m[6] = b6; m[7] = b7;
		return m;
	endfunction

	function automatic void reload_route();
		if (base_node) begin
			hop_cnt = 8'd0;
			parent_addr = uplink_addr;
		end else begin
			hop_cnt = HOP_NONE;
			parent_addr = bcast_addr;
		end
	endfunction

	function automatic bit sum_in_ring(input byte_t s);
		foreach (sum_ring[i])
			if (sum_ring[i] == s)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void ring_insert(input byte_t s);
		sum_ring[ring_slot] = s;
		ring_slot = (ring_slot + 1) % RING_DEPTH;
	endfunction

	// what the node sends, if anything, for one received message
	function automatic void forward_decision(input logic [1:0] op, input msg_t m);
		byte_t s;
		byte_t h;
		s = 8'd0;
		for (int i = 0; i < MSG_BYTES; i++)
			s = s + m[i];
		case (op)
		OP_BEACON: begin
			h = m[1];
			if (h > MAX_HOPS || h > hop_cnt || sum_in_ring(s)) begin
				msgs_dropped++;
				return;
			end
			ring_insert(s);
			epoch = m[0];
			hop_cnt = h;
			parent_addr = m[h + 1];
			m[1] = h + 8'd1;
			m[h + 2] = local_addr;
			outbound_msgs.push_back('{bcast_addr, HND_BEACON, m});
		end
		OP_DATA: begin
			if (parent_addr == 8'd0) begin
				msgs_dropped++;
				return;
			end
			if (!base_node) begin
				m[5] = m[4];
				m[4] = m[3];
				m[3] = m[2];
				m[2] = local_addr;
			end
			outbound_msgs.push_back('{parent_addr, HND_DATA, m});
		end
		OP_CAPSULE: begin
			if (sum_in_ring(s)) begin
				msgs_dropped++;
				return;
			end
			ring_insert(s);
			outbound_msgs.push_back('{bcast_addr, HND_CAPSULE, m});
		end
		default: msgs_dropped++;
		endcase
	endfunction

	task automatic send_msg(input logic [1:0] op, input msg_t m);
		if (sender_gaps && burst_left == 0) begin
			rx_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		rx_if.valid <= 1'b1;
		rx_if.opcode <= op;
		rx_if.in_byte0 <= m[0];
		rx_if.in_byte1 <= m[1];
		rx_if.in_byte2 <= m[2];
		rx_if.in_byte3 <= m[3];
		rx_if.in_byte4 <= m[4];
		rx_if.in_byte5 <= m[5];
		rx_if.in_byte6 <= m[6];
		rx_if.in_byte7 <= m[7];
		do
			@(posedge clk);
		while (rx_if.ready !== 1'b1);
		forward_decision(op, m);
		sent_log.push_back('{op, m});
		if (sent_log.size() > 16)
			void'(sent_log.pop_front());
		items_sent++;
	endtask

	// block must be quiet before a register write: dropped messages leave no beat
	task automatic settle();
		rx_if.valid <= 1'b0;
		while (outbound_msgs.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input byte_t val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
		REG_LOCAL:  local_addr = val;
		REG_BASE: begin
			base_node = val[0];
			reload_route();
		end
		REG_BCAST:  bcast_addr = val;
		REG_UPLINK: uplink_addr = val;
		default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_defaults();
		send_msg(OP_DATA, msg8(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_msg(OP_UNUSED, msg8(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		// sums to zero, matches the cleared ring
		send_msg(OP_CAPSULE, msg8(8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	task automatic test_beacons();
		msg_t bcn;
		bcn = msg8(8'h11, 8'd3, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26);
		send_msg(OP_BEACON, msg8(8'h10, 8'd6, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06));
		send_msg(OP_BEACON, bcn);
		send_msg(OP_BEACON, bcn);
		send_msg(OP_BEACON, msg8(8'h13, 8'd4, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36));
		// zero hops: parent comes from the hop byte itself
		send_msg(OP_BEACON, msg8(8'h12, 8'd0, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46));
		send_msg(OP_DATA, msg8(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08));
	endtask

	task automatic test_capsules();
		msg_t cap;
		cap = msg8(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08);
		send_msg(OP_CAPSULE, cap);
		send_msg(OP_CAPSULE, cap);
		for (int i = 0; i < 6; i++)
			send_msg(OP_CAPSULE, msg8(byte_t'(8'h40 + i), 8'h17, 8'h29, 8'h33, 8'h00,
				8'hFF, 8'h5A, 8'hA5));
		// every slot overwritten by now, so a zero sum is new again
		send_msg(OP_CAPSULE, msg8(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	task automatic test_registers();
		settle();
		write_reg(REG_UPLINK, 8'd0);
		write_reg(REG_BASE, 8'd1);
		send_msg(OP_DATA, msg8(8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11));
		settle();
		write_reg(REG_UPLINK, 8'd200);
		write_reg(REG_BASE, 8'd1);
		send_msg(OP_DATA, msg8(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		settle();
		write_reg(REG_LOCAL, 8'd255);
		write_reg(REG_BCAST, 8'd0);
		write_reg(REG_BASE, 8'd0);
		send_msg(OP_DATA, msg8(8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28));
		send_msg(OP_BEACON, msg8(8'h77, 8'd5, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66));
		send_msg(OP_CAPSULE, msg8(8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98));
		settings_used += 3;
	endtask

	task automatic test_backpressure();
		msg_t m;
		settle();
		sender_gaps = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 10; i++) begin
			for (int k = 0; k < MSG_BYTES; k++)
				m[k] = byte_t'($urandom);
			send_msg((i % 2) ? OP_DATA : OP_CAPSULE, m);
		end
		sender_gaps = 1'b1;
	endtask

	task automatic test_random();
		msg_t m;
		logic [1:0] op;
		int pick;
		byte_t lim;
		rx_beat_t old;
		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			case (p)
			0: begin
				write_reg(REG_LOCAL, 8'd0);
				write_reg(REG_BCAST, 8'd0);
				write_reg(REG_UPLINK, 8'd255);
				write_reg(REG_BASE, 8'd0);
			end
			1: begin
				write_reg(REG_LOCAL, 8'd255);
				write_reg(REG_BCAST, 8'd255);
				write_reg(REG_UPLINK, 8'd0);
				write_reg(REG_BASE, 8'd1);
			end
			default: begin
				write_reg(REG_LOCAL, byte_t'($urandom));
				write_reg(REG_BCAST, byte_t'($urandom));
				write_reg(REG_UPLINK, byte_t'($urandom));
				write_reg(REG_BASE, byte_t'($urandom_range(0, 1)));
			end
			endcase
			settings_used++;
			// every third phase runs back to back
			sender_gaps = (p % 3 != 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				for (int k = 0; k < MSG_BYTES; k++)
					m[k] = byte_t'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					// well-formed beacon that passes the hop test
					lim = (hop_cnt > MAX_HOPS) ? MAX_HOPS : hop_cnt;
					m[1] = $urandom_range(0, 1) ? lim : byte_t'($urandom_range(0, lim));
					op = OP_BEACON;
				end else if (pick < 62) begin
					op = OP_DATA;
				end else if (pick < 82) begin
					op = OP_CAPSULE;
				end else if (pick < 90) begin
					op = OP_CAPSULE;
					if (sent_log.size() != 0) begin
						old = sent_log[$urandom_range(0, sent_log.size() - 1)];
						op = old.op;
						m = old.body;
					end
				end else if (pick < 95) begin
					op = OP_BEACON;
				end else begin
					op = OP_UNUSED;
				end
				send_msg(op, m);
			end
		end
		sender_gaps = 1'b1;
	endtask

	// outgoing side: check each beat, then pick next cycle's ready
	always @(posedge clk) begin : tx_check
		tx_beat_t seen;
		tx_beat_t want;
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (arst_n && tx_if.valid === 1'b1 && tx_if.ready === 1'b1) begin
			seen.dest = tx_if.out_dest;
			seen.handler = tx_if.out_handler;
			seen.body = msg8(tx_if.out_byte0, tx_if.out_byte1, tx_if.out_byte2,
				tx_if.out_byte3, tx_if.out_byte4, tx_if.out_byte5, tx_if.out_byte6,
				tx_if.out_byte7);
			if (outbound_msgs.size() == 0) begin
				report_mismatch($sformatf("beat to %0d with nothing pending", seen.dest));
			end else begin
				want = outbound_msgs.pop_front();
				beats_checked++;
				if (seen.dest !== want.dest)
					report_mismatch($sformatf("out_dest got %0d want %0d",
						seen.dest, want.dest));
				if (seen.handler !== want.handler)
					report_mismatch($sformatf("out_handler got %0d want %0d",
						seen.handler, want.handler));
				for (int k = 0; k < MSG_BYTES; k++)
					if (seen.body[k] !== want.body[k])
						report_mismatch($sformatf("out_byte%0d got %02h want %02h",
							k, seen.body[k], want.body[k]));
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			tx_if.ready <= 1'b0;
		end else begin
			if (stall_cnt == 0) begin
				stall_mode = rx_pace_e'($urandom_range(0, 3));
				stall_cnt = $urandom_range(20, 120);
			end
			stall_cnt--;
			case (stall_mode)
			RX_STEADY:   tx_if.ready <= 1'b1;
			RX_COIN:     tx_if.ready <= 1'($urandom_range(0, 1));
			RX_LIGHT:    tx_if.ready <= ($urandom_range(0, 3) != 0);
			default:     tx_if.ready <= stall_cnt[2];
			endcase
		end
	end

	always @(posedge clk) begin
		if ((rx_if.valid === 1'b1 && rx_if.ready === 1'b1) ||
			(tx_if.valid === 1'b1 && tx_if.ready === 1'b1))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("no beat for %0d cycles", QUIET_LIMIT);
			$display("beacon_route_with_duplicate_filter_top test failed");
			$finish;
		end
	end

	initial begin
		rx_if.valid = 1'b0;
		rx_if.opcode = OP_BEACON;
		rx_if.in_byte0 = 8'd0;
		rx_if.in_byte1 = 8'd0;
		rx_if.in_byte2 = 8'd0;
		rx_if.in_byte3 = 8'd0;
		rx_if.in_byte4 = 8'd0;
		rx_if.in_byte5 = 8'd0;
		rx_if.in_byte6 = 8'd0;
		rx_if.in_byte7 = 8'd0;
		tx_if.ready = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_LOCAL;
		wr_data = 8'd0;
		arst_n = 1'b0;
		errors = 0;
		items_sent = 0;
		beats_checked = 0;
		msgs_dropped = 0;
		settings_used = 1;
		burst_left = 0;
		sender_gaps = 1'b1;
		hold_req = 1'b0;
		hold_left = 0;
		stall_cnt = 0;
		stall_mode = RX_STEADY;
		quiet = 0;

		local_addr = RST_LOCAL;
		base_node = 1'b0;
		bcast_addr = RST_BCAST;
		uplink_addr = RST_UPLINK;
		foreach (sum_ring[i])
			sum_ring[i] = 8'd0;
		ring_slot = 0;
		epoch = 8'd0;
		reload_route();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_beacons();
		test_capsules();
		test_registers();
		test_backpressure();
		test_random();

		settle();
		repeat (10) @(posedge clk);
		if (outbound_msgs.size() != 0)
			report_mismatch($sformatf("%0d expected beats never came", outbound_msgs.size()));

		$display("%0d messages (beacons, data, capsules, unused kind, replays) over %0d settings",
			items_sent, settings_used);
		$display("%0d outgoing beats checked, %0d messages dropped", beats_checked, msgs_dropped);
		if (errors == 0)
			$display("beacon_route_with_duplicate_filter_top test passed");
		else
			$display("beacon_route_with_duplicate_filter_top test failed");
		$finish;
	end

endmodule

FILE: sim.f
sv/brdf_pkg.sv
sv/brdf_if.sv
sv/brdf_filter.sv
sv/beacon_route_with_duplicate_filter_top.sv
tb/beacon_route_with_duplicate_filter_top_test.sv
